// ===== design/psw_pkg.sv =====
`default_nettype none

package psw_pkg;

  // Sizes
  localparam int MAX_PATTERN = 16;
  localparam int MAX_TEXT    = 65536;
  localparam int POS_W       = $clog2(MAX_TEXT + 1);
  localparam int LEN_W       = 5;
  localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int START_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  // Result queue, depth a power of two
  localparam int RES_DEPTH   = 4;
  localparam int RES_PTR_W   = $clog2(RES_DEPTH);
  localparam int RES_CNT_W   = $clog2(RES_DEPTH + 1);

  // Characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CASE_GAP = 8'h20;

  typedef enum logic [1:0] {
    MODE_CONTAINS = 2'd0,
    MODE_WORD     = 2'd1,
    MODE_STARTS   = 2'd2,
    MODE_ENDS     = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LO  = 3'd0,
    REG_PAT_HI  = 3'd1,
    REG_PAT_LEN = 3'd2,
    REG_CASE    = 3'd3,
    REG_MODE    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic               overflow;
    logic               last_result;
    logic               match_valid;
    logic [START_W-1:0] match_start;
  } result_t;

  typedef struct packed {
    logic shift;
    logic fold;
  } cell_ctrl_t;

  function automatic logic is_white(input logic [7:0] c);
    is_white = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_FF) || (c == CH_VT) || (c == CH_CR);
  endfunction

  function automatic logic is_word_byte(input logic [7:0] c);
    is_word_byte = ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
                   ((c >= CH_LO_A) && (c <= CH_LO_Z)) || (c == CH_UNDER);
  endfunction

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic fold_en);
    if (fold_en && (c >= CH_LO_A) && (c <= CH_LO_Z)) begin
      fold_byte = c - CASE_GAP;
    end else begin
      fold_byte = c;
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/psw_cell.sv =====
`default_nettype none

module psw_cell (
  input  logic                 clk,
  input  psw_pkg::cell_ctrl_t  ctrl,
  input  logic [7:0]           data_in,
  input  logic [7:0]           pattern_byte,
  input  logic                 active,
  output logic [7:0]           data_out,
  output logic                 hit
);
  import psw_pkg::*;

  logic [7:0] held;

  // Take the byte from the upstream neighbor on each accepted item
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      held <= data_in;
    end
  end

  assign data_out = held;

  // Compare the byte entering this cell; cells past the pattern always hit
  assign hit = !active || (fold_byte(data_in, ctrl.fold) == fold_byte(pattern_byte, ctrl.fold));

endmodule

`default_nettype wire

// ===== design/psw_result_fifo.sv =====
`default_nettype none

module psw_result_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_first,
  input  logic              push_second,
  input  psw_pkg::result_t  first_item,
  input  psw_pkg::result_t  second_item,
  input  logic              pop,
  output logic              head_valid,
  output psw_pkg::result_t  head_item,
  output logic              room
);
  import psw_pkg::*;

  result_t                slots [RES_DEPTH];
  logic [RES_PTR_W-1:0]   wr_ptr;
  logic [RES_PTR_W-1:0]   rd_ptr;
  logic [RES_CNT_W-1:0]   count;
  logic [RES_PTR_W-1:0]   wr_ptr_second;
  logic [RES_CNT_W-1:0]   count_next;
  logic [RES_PTR_W-1:0]   wr_ptr_next;

  assign wr_ptr_second = RES_PTR_W'(wr_ptr + 1'b1);

  // Write up to two items per cycle
  always_ff @(posedge clk) begin
    if (push_first) begin
      slots[wr_ptr] <= first_item;
    end
    if (push_second) begin
      slots[wr_ptr_second] <= second_item;
    end
  end

  always_comb begin
    count_next = count + RES_CNT_W'(push_first) + RES_CNT_W'(push_second)
                 - RES_CNT_W'(pop);
    wr_ptr_next = wr_ptr;
    if (push_second) begin
      wr_ptr_next = RES_PTR_W'(wr_ptr + 2'd2);
    end else if (push_first) begin
      wr_ptr_next = wr_ptr_second;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= RES_PTR_W'(rd_ptr + 1'b1);
      end
    end
  end

  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];
  assign room       = (count <= RES_CNT_W'(RES_DEPTH - 2));

endmodule

`default_nettype wire

// ===== design/pattern_search_with_word_modes.sv =====
// A result is queued as its item is accepted and goes out on m_axis from the queue head.
// Throughput: one text byte per cycle; an item may yield two results, which drain at one
// per cycle through a four-entry result queue, and s_axis_tready drops while it holds
// more than two results.
// Reset: synchronous rst restores the registers to their defaults and clears position,
// skip count, pending match, overflow and the result queue; the byte window is not reset.
`default_nettype none

module pattern_search_with_word_modes (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] text_byte
  input  logic                              s_axis_tlast,  // last_byte
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [psw_pkg::START_W-1:0]       m_axis_tdata,  // [15:0] match_start
  output logic [1:0]                        m_axis_tuser,  // [0] match_valid, [1] overflow
  output logic                              m_axis_tlast,  // last_result
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [psw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psw_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import psw_pkg::*;

  // Registers
  logic [CFG_DATA_W-1:0]  pat_lo;
  logic [CFG_DATA_W-1:0]  pat_hi;
  logic [LEN_W-1:0]       pat_len;
  logic                   case_sens;
  mode_t                  mode;

  // Text state
  logic [POS_W-1:0]       pos;
  logic [LEN_W-1:0]       skip;
  logic                   pend_valid;
  logic [POS_W-1:0]       pend_start;
  logic [7:0]             pend_before;
  logic                   pend_word;
  logic                   ovf;

  logic [POS_W-1:0]       pos_next;
  logic [LEN_W-1:0]       skip_next;
  logic                   pend_valid_next;
  logic [POS_W-1:0]       pend_start_next;
  logic [7:0]             pend_before_next;
  logic                   pend_word_next;
  logic                   ovf_next;

  logic [2*CFG_DATA_W-1:0] pat_all;
  logic [7:0]             pat_bytes [MAX_PATTERN];
  logic [LEN_W-1:0]       len_eff;
  cell_ctrl_t             cell_ctrl;
  logic [7:0]             cell_in   [MAX_PATTERN];
  logic [7:0]             cell_out  [MAX_PATTERN];
  logic [7:0]             cell_pat  [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_act;
  logic [MAX_PATTERN-1:0] cell_hit;

  logic                   in_fire;
  logic                   out_fire;
  logic                   room;
  logic [POS_W-1:0]       pos_inc;
  logic [POS_W-1:0]       len_ext;
  logic [POS_W-1:0]       start_pos;
  logic [IDX_W-1:0]       before_idx;
  logic [7:0]             before_byte;
  logic                   ovf_hit;
  logic                   edge_start;
  logic                   pend_ok;
  logic                   r0_valid;
  logic                   r1_valid;
  logic                   left_ok;
  logic                   push_first;
  logic                   push_second;
  result_t                first_item;
  result_t                second_item;
  result_t                r0;
  result_t                r1;
  result_t                head_item;

  assign cfg_ready     = 1'b1;
  assign in_fire       = s_axis_tvalid && room;
  assign s_axis_tready = room;
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_lo    <= '0;
      pat_hi    <= '0;
      pat_len   <= LEN_W'(1);
      case_sens <= 1'b1;
      mode      <= MODE_CONTAINS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PAT_LO:  pat_lo    <= cfg_data;
        REG_PAT_HI:  pat_hi    <= cfg_data;
        REG_PAT_LEN: pat_len   <= cfg_data[LEN_W-1:0];
        REG_CASE:    case_sens <= cfg_data[0];
        REG_MODE:    mode      <= mode_t'(cfg_data[1:0]);
        default: begin
        end
      endcase
    end
  end

  // Clamp length and line up pattern bytes with the cells, last pattern byte at cell 0
  assign pat_all = {pat_hi, pat_lo};
  assign len_eff = (pat_len > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len;
  assign cell_ctrl.shift = in_fire;
  assign cell_ctrl.fold  = !case_sens;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pat
    assign pat_bytes[k] = pat_all[k*8 +: 8];
  end

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [LEN_W-1:0] pat_idx;
    assign pat_idx     = LEN_W'(len_eff - LEN_W'(1) - LEN_W'(j));
    assign cell_act[j] = (LEN_W'(j) < len_eff);
    assign cell_pat[j] = pat_bytes[pat_idx[IDX_W-1:0]];
    if (j == 0) begin : g_head
      assign cell_in[j] = s_axis_tdata;
    end else begin : g_link
      assign cell_in[j] = cell_out[j-1];
    end
    psw_cell u_cell (
      .clk          (clk),
      .ctrl         (cell_ctrl),
      .data_in      (cell_in[j]),
      .pattern_byte (cell_pat[j]),
      .active       (cell_act[j]),
      .data_out     (cell_out[j]),
      .hit          (cell_hit[j])
    );
  end

  // Match position and the byte just before it
  assign pos_inc     = POS_W'(pos + 1'b1);
  assign len_ext     = POS_W'(len_eff);
  assign start_pos   = POS_W'(pos_inc - len_ext);
  assign edge_start  = (pos_inc == len_ext);
  assign before_idx  = IDX_W'(len_eff - LEN_W'(1));
  assign before_byte = cell_out[before_idx];
  assign ovf_hit     = (pos >= POS_W'(MAX_TEXT));

  // Decide the pending match, look for a new one and form the results
  always_comb begin
    pos_next         = pos;
    skip_next        = skip;
    pend_valid_next  = pend_valid;
    pend_start_next  = pend_start;
    pend_before_next = pend_before;
    pend_word_next   = pend_word;
    ovf_next         = ovf | ovf_hit;
    pend_ok          = 1'b0;
    r1_valid         = 1'b0;
    left_ok          = edge_start || is_white(before_byte);

    if (!ovf_hit) begin
      pos_next = pos_inc;
    end

    if (!pend_word || (pend_start == '0)) begin
      pend_ok = is_white(s_axis_tdata);
    end else begin
      pend_ok = !is_word_byte(pend_before) && !is_word_byte(s_axis_tdata);
    end
    r0_valid        = pend_valid && !ovf_hit && pend_ok;
    pend_valid_next = 1'b0;

    if (!ovf_next) begin
      if (skip != '0) begin
        skip_next = LEN_W'(skip - 1'b1);
      end else if ((len_eff != '0) && (pos_inc >= len_ext) && (&cell_hit)) begin
        skip_next = LEN_W'(len_eff - 1'b1);
        unique case (mode)
          MODE_CONTAINS: r1_valid = 1'b1;
          MODE_STARTS:   r1_valid = left_ok;
          MODE_WORD, MODE_ENDS: begin
            if (s_axis_tlast) begin
              r1_valid = (mode == MODE_ENDS) || left_ok;
            end else begin
              pend_valid_next  = 1'b1;
              pend_start_next  = start_pos;
              pend_before_next = before_byte;
              pend_word_next   = (mode == MODE_WORD);
            end
          end
          default: r1_valid = 1'b0;
        endcase
      end
    end

    r0.match_start = pend_start[START_W-1:0];
    r0.match_valid = 1'b1;
    r0.last_result = 1'b0;
    r0.overflow    = ovf_next;
    r1.match_start = start_pos[START_W-1:0];
    r1.match_valid = 1'b1;
    r1.last_result = s_axis_tlast;
    r1.overflow    = ovf_next;

    // Order: pending result, then new match, else end report on the last byte
    push_first  = in_fire && (r0_valid || r1_valid || s_axis_tlast);
    push_second = in_fire && r0_valid && r1_valid;
    second_item = r1;
    if (r0_valid) begin
      first_item = r0;
      first_item.last_result = s_axis_tlast && !r1_valid;
    end else if (r1_valid) begin
      first_item = r1;
    end else begin
      first_item.match_start = '0;
      first_item.match_valid = 1'b0;
      first_item.last_result = 1'b1;
      first_item.overflow    = ovf_next;
    end

    // Drop all text state after the last byte
    if (s_axis_tlast) begin
      pos_next         = '0;
      skip_next        = '0;
      pend_valid_next  = 1'b0;
      pend_start_next  = '0;
      pend_before_next = '0;
      pend_word_next   = 1'b0;
      ovf_next         = 1'b0;
    end
  end

  // Hold text state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      skip        <= '0;
      pend_valid  <= 1'b0;
      pend_start  <= '0;
      pend_before <= '0;
      pend_word   <= 1'b0;
      ovf         <= 1'b0;
    end else if (in_fire) begin
      pos         <= pos_next;
      skip        <= skip_next;
      pend_valid  <= pend_valid_next;
      pend_start  <= pend_start_next;
      pend_before <= pend_before_next;
      pend_word   <= pend_word_next;
      ovf         <= ovf_next;
    end
  end

  psw_result_fifo u_results (
    .clk         (clk),
    .rst         (rst),
    .push_first  (push_first),
    .push_second (push_second),
    .first_item  (first_item),
    .second_item (second_item),
    .pop         (out_fire),
    .head_valid  (m_axis_tvalid),
    .head_item   (head_item),
    .room        (room)
  );

  assign m_axis_tdata = head_item.match_start;
  assign m_axis_tuser = {head_item.overflow, head_item.match_valid};
  assign m_axis_tlast = head_item.last_result;

endmodule

`default_nettype wire

// ===== design/psw_checker.sv =====
`default_nettype none

module psw_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,
  input  logic                              s_axis_tlast,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [psw_pkg::START_W-1:0]       m_axis_tdata,
  input  logic [1:0]                        m_axis_tuser,
  input  logic                              m_axis_tlast,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [psw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psw_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // The queue is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result present after reset");

  // An end report carries no position and closes the text
  a_end_report: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("malformed end report");

  // The last byte of a text always leaves a result behind
  a_last_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
    else $error("no result after last byte");

endmodule

bind pattern_search_with_word_modes psw_checker u_psw_checker (.*);

`default_nettype wire

// ===== bench/search_result_checker.sv =====
module search_result_checker import psw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] text_byte
  input  logic                  s_axis_tlast,   // last_byte
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [START_W-1:0]    m_axis_tdata,   // [15:0] match_start
  input  logic [1:0]            m_axis_tuser,   // [0] match_valid, [1] overflow
  input  logic                  m_axis_tlast,   // last_result
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the search registers
  logic [63:0]      pat_lo;
  logic [63:0]      pat_hi;
  logic [LEN_W-1:0] pat_len;
  logic             exact;
  mode_t            mode;

  // Text scan state
  logic [7:0]  window [0:MAX_PATTERN];
  int unsigned text_pos;
  int unsigned skip_left;
  bit          held;
  int unsigned held_start;
  logic [7:0]  held_before;
  bit          held_word;
  bit          ovf;

  result_t matches_due[$];
  result_t got;
  result_t want;

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

  function automatic bit is_word_char(input logic [7:0] c);
    return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z) ||
           c == CH_UNDER;
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    if (!exact && c >= CH_LO_A && c <= CH_LO_Z) begin
      return c - CASE_GAP;
    end
    return c;
  endfunction

  function automatic logic [7:0] pat_byte(input int k);
    return (k < 8) ? pat_lo[k*8 +: 8] : pat_hi[(k-8)*8 +: 8];
  endfunction

  function automatic result_t make_result(input int unsigned start, input bit hit);
    result_t r;
    r.overflow    = ovf;
    r.last_result = 1'b0;
    r.match_valid = hit;
    r.match_start = start[START_W-1:0];
    return r;
  endfunction

  task automatic clear_text();
    int i;
    for (i = 0; i <= MAX_PATTERN; i++) begin
      window[i] = 8'h00;
    end
    text_pos    = 0;
    skip_left   = 0;
    held        = 1'b0;
    held_start  = 0;
    held_before = 8'h00;
    held_word   = 1'b0;
    ovf         = 1'b0;
  endtask

  // Work out the results that one text byte causes
  task automatic scan_byte(input logic [7:0] b, input logic fin);
    int unsigned len;
    int unsigned pos;
    int unsigned s;
    int          i;
    int          k;
    int          n;
    bit          ok;
    bit          hit;
    bit          at_edge;
    logic [7:0]  prev;
    result_t     res [2];
    len = (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
    pos = text_pos;
    n = 0;
    for (i = MAX_PATTERN; i > 0; i--) begin
      window[i] = window[i-1];
    end
    window[0] = b;

    // Saturate the position; past the end nothing is tracked
    if (pos >= MAX_TEXT) begin
      ovf = 1'b1;
      held = 1'b0;
    end else begin
      text_pos = pos + 1;
    end

    // Decide a deferred match with the byte that follows it
    if (held) begin
      if (!held_word || held_start == 0) begin
        ok = is_blank(b);
      end else begin
        ok = !is_word_char(held_before) && !is_word_char(b);
      end
      if (ok) begin
        res[n] = make_result(held_start, 1'b1);
        n++;
      end
      held = 1'b0;
    end

    if (!ovf) begin
      if (skip_left > 0) begin
        skip_left--;
      end else if (len > 0 && pos + 1 >= len) begin
        hit = 1'b1;
        for (k = 0; k < int'(len); k++) begin
          if (upcase(pat_byte(k)) != upcase(window[len-1-k])) begin
            hit = 1'b0;
          end
        end
        if (hit) begin
          s = pos + 1 - len;
          at_edge = (s == 0);
          prev = at_edge ? 8'h00 : window[len];
          skip_left = len - 1;
          case (mode)
            MODE_CONTAINS: begin
              res[n] = make_result(s, 1'b1);
              n++;
            end
            MODE_STARTS: begin
              if (at_edge || is_blank(prev)) begin
                res[n] = make_result(s, 1'b1);
                n++;
              end
            end
            default: begin
              if (fin) begin
                if (mode == MODE_ENDS || at_edge || is_blank(prev)) begin
                  res[n] = make_result(s, 1'b1);
                  n++;
                end
              end else begin
                held = 1'b1;
                held_start = s;
                held_before = prev;
                held_word = (mode == MODE_WORD);
              end
            end
          endcase
        end
      end
    end

    // Close the text with a marked result
    if (fin) begin
      if (n == 0) begin
        res[0] = make_result(0, 1'b0);
        n = 1;
      end
      res[n-1].last_result = 1'b1;
    end
    for (i = 0; i < n; i++) begin
      matches_due.push_back(res[i]);
    end
    if (fin) begin
      clear_text();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pat_lo  = '0;
      pat_hi  = '0;
      pat_len = 1;
      exact   = 1'b1;
      mode    = MODE_CONTAINS;
      clear_text();
      matches_due.delete();
    end else begin
      // Compare each delivered result with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got.overflow    = m_axis_tuser[1];
        got.last_result = m_axis_tlast;
        got.match_valid = m_axis_tuser[0];
        got.match_start = m_axis_tdata;
        if (matches_due.size() == 0) begin
          fail_count++;
          if (fail_count < 40) begin
            $display("%0t: unexpected result start=%0d valid=%0b last=%0b ovf=%0b",
                     $time, got.match_start, got.match_valid, got.last_result,
                     got.overflow);
          end
        end else begin
          want = matches_due.pop_front();
          if (got.match_start !== want.match_start || got.match_valid !== want.match_valid ||
              got.last_result !== want.last_result || got.overflow !== want.overflow) begin
            fail_count++;
            if (fail_count < 40) begin
              $display("%0t: mismatch expected start=%0d valid=%0b last=%0b ovf=%0b",
                       $time, want.match_start, want.match_valid, want.last_result,
                       want.overflow);
              $display("%0t:          actual   start=%0d valid=%0b last=%0b ovf=%0b",
                       $time, got.match_start, got.match_valid, got.last_result,
                       got.overflow);
            end
          end
        end
      end

      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_PAT_LO:  pat_lo = cfg_data;
          REG_PAT_HI:  pat_hi = cfg_data;
          REG_PAT_LEN: pat_len = cfg_data[LEN_W-1:0];
          REG_CASE:    exact = cfg_data[0];
          REG_MODE:    mode = mode_t'(cfg_data[1:0]);
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) begin
        scan_byte(s_axis_tdata, s_axis_tlast);
      end
    end
    results_due = matches_due.size();
  end

endmodule

// ===== bench/pattern_search_with_word_modes_tb.sv =====
module pattern_search_with_word_modes_tb import psw_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = 8'h00;   // [7:0] text_byte
  logic                  s_axis_tlast = 1'b0;    // last_byte
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [START_W-1:0]    m_axis_tdata;           // [15:0] match_start
  logic [1:0]            m_axis_tuser;           // [0] match_valid, [1] overflow
  logic                  m_axis_tlast;           // last_result
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    results_due;

  // Stimulus state
  bit         burst = 1'b0;
  bit         hold_req = 1'b0;
  logic [7:0] pat [MAX_PATTERN];
  bit         exact_cmp;
  logic [7:0] text_q[$];
  int         random_items = 0;
  logic [7:0] space_chars [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
  string      pat_chars = "aAbB_ -";
  string      word_chars = "abAB_zZ";
  string      mark_chars = ".,-!0";

  pattern_search_with_word_modes dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  search_result_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .results_due   (results_due)
  );

  always #5 clk = ~clk;

  // Hard stop
  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: random stalls, ready stretches, and one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if ($urandom_range(0, 99) < 2) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(30, 100)) @(posedge clk);
      end else if ($urandom_range(0, 3) != 0) begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_axis_tready <= 1'b0;
        repeat (($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) :
                $urandom_range(1, 3)) @(posedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (burst) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] pack_str(input string s, input int from);
    logic [63:0] w;
    w = '0;
    for (int k = 0; k < 8; k++) begin
      if (from + k < s.len()) begin
        w[k*8 +: 8] = s[from + k];
      end
    end
    return w;
  endfunction

  function automatic logic [7:0] twist_case(input logic [7:0] c);
    if ((c | CASE_GAP) >= CH_LO_A && (c | CASE_GAP) <= CH_LO_Z && $urandom_range(0, 1)) begin
      return c ^ CASE_GAP;
    end
    return c;
  endfunction

  // Offer one item; valid stays high after the handshake
  task automatic send_item(input logic [7:0] b, input bit fin, input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= fin;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], i == s.len() - 1, pick_gap());
    end
  endtask

  // Drop valid and wait until every predicted result is out
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it
  task automatic write_reg(input reg_idx_t idx, input logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_search(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [LEN_W-1:0] len, input bit exact_in,
                             input mode_t m);
    write_reg(REG_PAT_LO, lo);
    write_reg(REG_PAT_HI, hi);
    write_reg(REG_PAT_LEN, 64'(len));
    write_reg(REG_CASE, 64'(exact_in));
    write_reg(REG_MODE, 64'(m));
    cfg_valid <= 1'b0;
  endtask

  // Compose a text from pattern copies, spaces, word characters and noise
  task automatic build_text(input int eff_len);
    int         target;
    int         r;
    int         take;
    logic [7:0] c;
    text_q.delete();
    target = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 48) : $urandom_range(1, 20);
    while (text_q.size() < target) begin
      r = $urandom_range(0, 9);
      if (r <= 2 || r == 9) begin
        take = (r == 9) ? $urandom_range(0, eff_len) : eff_len;
        for (int k = 0; k < take; k++) begin
          c = (!exact_cmp || $urandom_range(0, 7) == 0) ? twist_case(pat[k]) : pat[k];
          text_q.push_back((c == 8'h00) ? 8'h01 : c);
        end
      end else if (r <= 4) begin
        text_q.push_back(space_chars[$urandom_range(0, 5)]);
      end else if (r <= 6) begin
        text_q.push_back(word_chars[$urandom_range(0, word_chars.len() - 1)]);
      end else if (r == 7) begin
        text_q.push_back(mark_chars[$urandom_range(0, mark_chars.len() - 1)]);
      end else begin
        text_q.push_back(8'($urandom_range(1, 255)));
      end
    end
  endtask

  initial begin
    logic [63:0]      lo;
    logic [63:0]      hi;
    logic [LEN_W-1:0] len;
    mode_t            m;
    int               eff;
    int               r;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: each mode rule, zero length, and a mode change inside a text
    load_search(pack_str("aB", 0), '0, 5'd2, 1'b0, MODE_STARTS);
    send_str("ab Ab");
    settle();
    load_search(pack_str("aB", 0), '0, 5'd2, 1'b0, MODE_ENDS);
    send_str("ab\tab");
    settle();
    load_search(pack_str("aB", 0), '0, 5'd2, 1'b0, MODE_WORD);
    send_str("ab,ab-");
    settle();
    load_search(pack_str("a", 0), '0, 5'd0, 1'b1, MODE_CONTAINS);
    send_str("aa");
    settle();
    load_search(pack_str("ab", 0), '0, 5'd2, 1'b1, MODE_WORD);
    send_item("a", 1'b0, 0);
    send_item("b", 1'b0, 0);
    settle();
    write_reg(REG_MODE, 64'(MODE_CONTAINS));
    cfg_valid <= 1'b0;
    send_item(" ", 1'b0, 1);
    send_item("a", 1'b0, 0);
    send_item("b", 1'b1, 0);
    settle();

    // Hold off the result side while the input keeps coming
    load_search(pack_str("a", 0), '0, 5'd1, 1'b1, MODE_CONTAINS);
    hold_req = 1'b1;
    while (hold_req) @(posedge clk);
    for (int i = 0; i < 40; i++) begin
      send_item("a", i == 39, 0);
    end
    settle();

    // Random settings, each followed by a few texts
    while (random_items < 1150) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        len = 0;
      end else if (r == 1) begin
        len = LEN_W'($urandom_range(17, 31));
      end else if (r <= 3) begin
        len = LEN_W'(MAX_PATTERN);
      end else begin
        len = LEN_W'($urandom_range(1, 5));
      end
      for (int k = 0; k < 8; k++) begin
        lo[k*8 +: 8] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
                       pat_chars[$urandom_range(0, pat_chars.len() - 1)];
        hi[k*8 +: 8] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
                       pat_chars[$urandom_range(0, pat_chars.len() - 1)];
      end
      if ($urandom_range(0, 9) == 0) lo = {$urandom, $urandom};
      if ($urandom_range(0, 9) == 0) hi = {$urandom, $urandom};
      for (int k = 0; k < MAX_PATTERN; k++) begin
        pat[k] = (k < 8) ? lo[k*8 +: 8] : hi[(k-8)*8 +: 8];
      end
      exact_cmp = $urandom_range(0, 1);
      m = mode_t'($urandom_range(0, 3));
      eff = (len > MAX_PATTERN) ? MAX_PATTERN : len;
      load_search(lo, hi, len, exact_cmp, m);
      burst = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 5)) begin
        build_text(eff);
        foreach (text_q[i]) begin
          send_item(text_q[i], i == text_q.size() - 1, pick_gap());
        end
        random_items += text_q.size();
      end
      burst = 1'b0;
      settle();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
